// ===== hw/rtl/spims_pkg.sv =====
// Shared types and constants for the SPI master byte shifter.
// Used by spims_csr, spims_core and spi_master_byte_shifter; depends on nothing.
package spims_pkg;

   localparam int WORD_W = 8;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int RX_W   = 8;
   localparam int TX_W   = 8;
   localparam int FREQ_W = 26;
   localparam int DIV_W  = FREQ_W + 1;
   localparam int TICK_W = 19;
   localparam int CNT_W  = TICK_W + 1;
   localparam int PROD_W = CNT_W + DIV_W;
   localparam int MODE_W = 2;
   localparam int ADDR_W = 1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_BITS   = RX_W + 5;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   localparam logic [BIT_W-1:0]  LAST_BIT     = BIT_W'(WORD_W - 1);
   localparam logic [FREQ_W-1:0] DEFAULT_FREQ = FREQ_W'(500000);
   localparam logic [DIV_W-1:0]  RESET_TWICE  = DIV_W'(1000000);
   localparam logic [PROD_W-1:0] TICKS_PER_S  = PROD_W'(1000000);

   localparam logic [ADDR_W-1:0] REG_FREQ = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] REG_MODE = ADDR_W'(1);

   typedef enum logic [MODE_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_START  = 2'd1,
      CMD_SELECT = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [DIV_W-1:0] twice_freq;
      logic             cpol;
      logic             cpha;
   } cfg_type;

   typedef struct packed {
      cmd_type         mode;
      logic [TX_W-1:0] tx_byte;
      logic            select_level;
      logic            miso_level;
   } item_type;

   typedef struct packed {
      logic [RX_W-1:0] rx_byte;
      logic            done_res;
      logic            busy_res;
      logic            cs_n_level;
      logic            mosi_level;
      logic            sck_level;
   } result_type;

endpackage

// ===== hw/rtl/spi_master_byte_shifter.sv =====
// SPI master byte shifter, CPOL/CPHA modes 0..3, MSB first.
// Usage: each req_ item is a command: a 1 us tick carrying MISO, the start of a
// byte exchange, or a chip-select change. Every item yields exactly one rsp_
// item with the pin levels after it (SCK, MOSI, CS_n), busy, done and rx_byte.
// The SCK half period is 1e6 / (2 * clock_frequency_hz) ticks, at least one.
// Write csr_ registers only when no item is in flight.
// An item is taken into the input register, processed in one pass, and its
// result is loaded into the result register, from which rsp_ takes it.
// Throughput: one item per cycle when rsp_ does not stall, set by the single
// state update.
// If rsp_tready is low, the result register holds its item and the input
// register holds the next one; req_tready drops only when both are full.
// Reset (synchronous): SCK 0, MOSI 0, CS_n 1, idle, 500 kHz, mode 0, both
// registers empty.
// Depends on spims_pkg, spims_csr and spims_core.
module spi_master_byte_shifter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: tx_byte[7:0], select_level[8], miso_level[9], zero pad
   input  logic [spims_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: mode[1:0]
   input  logic [spims_pkg::MODE_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: sck_level[0], mosi_level[1], cs_n_level[2], busy_res[3],
   //        done_res[4], rx_byte[12:5], zero pad
   output logic [spims_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [spims_pkg::ADDR_W-1:0]      csr_addr,
   input  logic [spims_pkg::FREQ_W-1:0]      csr_wdata
);

   spims_pkg::cfg_type    cfg;
   spims_pkg::item_type   req_item;
   spims_pkg::item_type   in_ff;
   logic                  in_valid_ff, in_valid_in;
   spims_pkg::result_type step_res;
   spims_pkg::result_type rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  take;

   assign req_item.mode         = spims_pkg::cmd_type'(req_tuser);
   assign req_item.tx_byte      = req_tdata[spims_pkg::TX_W-1:0];
   assign req_item.select_level = req_tdata[spims_pkg::TX_W];
   assign req_item.miso_level   = req_tdata[spims_pkg::TX_W+1];

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   spims_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spims_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{spims_pkg::RSP_PAD_W{1'b0}}, rsp_ff};

   // A finished exchange reports idle in the same item.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.done_res |-> !step_res.busy_res)
      else $error("done reported while still busy");

   // Only a tick can complete the last bit.
   a_done_tick: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.done_res |-> in_ff.mode == spims_pkg::CMD_TICK)
      else $error("done raised by a non-tick item");

   // The received byte is shown only with done.
   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      advance && !step_res.done_res |-> step_res.rx_byte == '0)
      else $error("rx_byte nonzero without done");

   // A processed item is loaded into the result register on the next edge.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item lost before the result register");

endmodule

// ===== hw/rtl/spims_csr.sv =====
// Configuration registers of the SPI master: SCK rate and clock mode.
// Depends on spims_pkg; feeds spims_core through spims_pkg::cfg_type.
module spims_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [spims_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [spims_pkg::FREQ_W-1:0]  csr_wdata,
   output spims_pkg::cfg_type            cfg
);

   logic [spims_pkg::DIV_W-1:0]  twice_ff, twice_in;
   logic                         cpol_ff, cpol_in;
   logic                         cpha_ff, cpha_in;
   logic [spims_pkg::FREQ_W-1:0] freq_eff;

   // Keep 2*f rather than the half period; the core scales the tick count by it.
   assign freq_eff = (csr_wdata == '0) ? spims_pkg::DEFAULT_FREQ : csr_wdata;

   always_comb begin
      twice_in = twice_ff;
      cpol_in  = cpol_ff;
      cpha_in  = cpha_ff;
      if (csr_we) begin
         case (csr_addr)
            spims_pkg::REG_FREQ: begin
               twice_in = {freq_eff, 1'b0};
            end
            spims_pkg::REG_MODE: begin
               cpol_in = csr_wdata[1];
               cpha_in = csr_wdata[0];
            end
            default: begin
               twice_in = twice_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         twice_ff <= spims_pkg::RESET_TWICE;
         cpol_ff  <= 1'b0;
         cpha_ff  <= 1'b0;
      end else begin
         twice_ff <= twice_in;
         cpol_ff  <= cpol_in;
         cpha_ff  <= cpha_in;
      end
   end

   assign cfg.twice_freq = twice_ff;
   assign cfg.cpol       = cpol_ff;
   assign cfg.cpha       = cpha_ff;

endmodule

// ===== hw/rtl/spims_core.sv =====
// Shifter state and the single-pass update for one item.
// Depends on spims_pkg; the top level registers the result it returns.
module spims_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  spims_pkg::item_type   item,
   input  spims_pkg::cfg_type    cfg,
   output spims_pkg::result_type result
);

   // tick_ff counts ticks in the current half. The half ends on the tick that
   // brings the count to 1e6 / (2f), clamped to 1, which is the same as
   // (count + 2) * 2f > 1e6; a new rate takes hold on the next tick.
   logic [spims_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [spims_pkg::BIT_W-1:0]  bit_ff, bit_in;
   logic                         phase_ff, phase_in;
   logic [spims_pkg::WORD_W-1:0] tx_ff, tx_in;
   logic [spims_pkg::WORD_W-1:0] rx_ff, rx_in;
   logic                         active_ff, active_in;
   logic                         sck_ff, sck_in;
   logic                         mosi_ff, mosi_in;
   logic                         cs_n_ff, cs_n_in;

   logic [spims_pkg::WORD_W-1:0] rx_smp;
   logic [spims_pkg::WORD_W-1:0] tx_word;
   logic [spims_pkg::CNT_W-1:0]  tick_two;
   logic [spims_pkg::PROD_W-1:0] half_prod;
   logic                         half_end;
   logic                         done;
   logic [spims_pkg::RX_W-1:0]   rx_out;

   assign rx_smp    = {rx_ff[spims_pkg::WORD_W-2:0], item.miso_level};
   assign tx_word   = spims_pkg::WORD_W'(item.tx_byte);
   assign tick_two  = {1'b0, tick_ff} + spims_pkg::CNT_W'(2);
   assign half_prod = spims_pkg::PROD_W'(tick_two) * spims_pkg::PROD_W'(cfg.twice_freq);
   assign half_end  = half_prod > spims_pkg::TICKS_PER_S;

   always_comb begin
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      phase_in  = phase_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      active_in = active_ff;
      sck_in    = sck_ff;
      mosi_in   = mosi_ff;
      cs_n_in   = cs_n_ff;
      done      = 1'b0;
      rx_out    = '0;
      case (item.mode)
         spims_pkg::CMD_TICK: begin
            if (active_ff) begin
               if (!half_end) begin
                  tick_in = tick_ff + spims_pkg::TICK_W'(1);
               end else begin
                  tick_in = '0;
                  if (!phase_ff) begin
                     if (!cfg.cpha) begin
                        rx_in = rx_smp;
                     end
                     sck_in   = cfg.cpol;
                     phase_in = 1'b1;
                  end else begin
                     if (cfg.cpha) begin
                        rx_in = rx_smp;
                     end
                     if (bit_ff == spims_pkg::LAST_BIT) begin
                        active_in = 1'b0;
                        bit_in    = '0;
                        phase_in  = 1'b0;
                        sck_in    = cfg.cpol;
                        done      = 1'b1;
                        rx_out    = spims_pkg::RX_W'(cfg.cpha ? rx_smp : rx_ff);
                     end else begin
                        // advance to the next bit, MSB first
                        tx_in    = {tx_ff[spims_pkg::WORD_W-2:0], 1'b0};
                        mosi_in  = tx_ff[spims_pkg::WORD_W-2];
                        sck_in   = ~cfg.cpol;
                        phase_in = 1'b0;
                        bit_in   = bit_ff + spims_pkg::BIT_W'(1);
                     end
                  end
               end
            end
         end
         spims_pkg::CMD_START: begin
            // drop a start that arrives mid-exchange
            if (!active_ff) begin
               active_in = 1'b1;
               bit_in    = '0;
               phase_in  = 1'b0;
               tick_in   = '0;
               tx_in     = tx_word;
               rx_in     = '0;
               mosi_in   = tx_word[spims_pkg::WORD_W-1];
               sck_in    = ~cfg.cpol;
            end
         end
         spims_pkg::CMD_SELECT: begin
            cs_n_in = ~item.select_level;
         end
         default: begin
            cs_n_in = cs_n_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         bit_ff    <= '0;
         phase_ff  <= 1'b0;
         tx_ff     <= '0;
         rx_ff     <= '0;
         active_ff <= 1'b0;
         sck_ff    <= 1'b0;
         mosi_ff   <= 1'b0;
         cs_n_ff   <= 1'b1;
      end else if (step_en) begin
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         phase_ff  <= phase_in;
         tx_ff     <= tx_in;
         rx_ff     <= rx_in;
         active_ff <= active_in;
         sck_ff    <= sck_in;
         mosi_ff   <= mosi_in;
         cs_n_ff   <= cs_n_in;
      end
   end

   assign result.rx_byte    = rx_out;
   assign result.done_res   = done;
   assign result.busy_res   = active_in;
   assign result.cs_n_level = cs_n_in;
   assign result.mosi_level = mosi_in;
   assign result.sck_level  = sck_in;

endmodule

// ===== dv/spi_master_byte_shifter_tb.sv =====
// Self-checking testbench for spi_master_byte_shifter: a short directed script, then random
// SPI byte exchanges under several clock rates and modes, with random gaps and back-pressure
// except in the random phases. Depends only on spims_pkg and the spi_master_byte_shifter RTL.
module spi_master_byte_shifter_tb;

   localparam logic [spims_pkg::MODE_W-1:0] CMD_NOP = 2'd3;
   localparam int SETTLE_CYCLES = 4;
   localparam int NUM_PHASES    = 10;
   localparam int FIRST_RANDOM  = 7;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [spims_pkg::MODE_W-1:0] mode;
      logic [spims_pkg::TX_W-1:0]   tx_byte;
      logic                         select_level;
      logic                         miso_level;
   } spi_cmd_type;

   typedef struct packed {
      logic                  fixed;
      spims_pkg::result_type pins;
      spi_cmd_type           cmd;
   } script_row_type;

   // pins: rx_byte, then {done, busy, cs_n, mosi, sck}
   localparam script_row_type SCRIPT [0:24] = '{
      {1'b1, 8'h00, 5'b00100, spims_pkg::CMD_TICK,   8'hA5, 1'b0, 1'b1},
      {1'b1, 8'h00, 5'b00100, CMD_NOP,               8'hFF, 1'b1, 1'b1},
      {1'b1, 8'h00, 5'b00000, spims_pkg::CMD_SELECT, 8'h00, 1'b1, 1'b0},
      {1'b1, 8'h00, 5'b01011, spims_pkg::CMD_START,  8'hFF, 1'b0, 1'b0},
      {1'b1, 8'h00, 5'b01011, spims_pkg::CMD_START,  8'h00, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h00, 1'b0, 1'b1},
      {1'b1, 8'hFF, 5'b10010, spims_pkg::CMD_TICK,   8'hFF, 1'b1, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_SELECT, 8'h00, 1'b0, 1'b1},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_START,  8'h00, 1'b0, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_TICK,   8'h5A, 1'b0, 1'b0},
      {1'b0, 8'h00, 5'b00000, spims_pkg::CMD_SELECT, 8'h00, 1'b1, 1'b1}
   };

   localparam logic [spims_pkg::FREQ_W-1:0] PHASE_FREQ [0:FIRST_RANDOM-1] = '{
      26'd0, 26'd50000000, 26'd250000, 26'd125000, 26'd1, 26'd333333, 26'd500000
   };
   localparam logic [1:0] PHASE_MODE [0:FIRST_RANDOM-1] = '{
      2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1
   };

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [spims_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [spims_pkg::MODE_W-1:0]     req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [spims_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_we;
   logic [spims_pkg::ADDR_W-1:0]     csr_addr;
   logic [spims_pkg::FREQ_W-1:0]     csr_wdata;

   // predicted shifter state and configuration
   logic [18:0]                half_ticks;
   logic [18:0]                tick_cnt;
   logic [3:0]                 bit_idx;
   logic                       idle_half;
   logic [spims_pkg::TX_W-1:0] tx_sr;
   logic [spims_pkg::RX_W-1:0] rx_sr;
   logic                       xfer_busy;
   logic                       sck_q;
   logic                       mosi_q;
   logic                       cs_n_q;
   logic                       cpol_q;
   logic                       cpha_q;

   spims_pkg::result_type pins_due [$];
   int                    bad_results = 0;
   int                    send_gap_pct;
   int                    rsp_stall_pct;

   spi_master_byte_shifter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Advance the predicted shifter by one command and return the pins after it.
   function automatic spims_pkg::result_type next_pins(input spi_cmd_type c);
      spims_pkg::result_type r;
      logic                  done;
      logic [7:0]            rx;
      done = 1'b0;
      rx   = '0;
      case (c.mode)
         spims_pkg::CMD_TICK: begin
            if (xfer_busy) begin
               tick_cnt = tick_cnt + 19'd1;
               if (tick_cnt >= half_ticks) begin
                  tick_cnt = '0;
                  if (!idle_half) begin
                     if (!cpha_q) rx_sr = {rx_sr[spims_pkg::RX_W-2:0], c.miso_level};
                     sck_q     = cpol_q;
                     idle_half = 1'b1;
                  end else begin
                     if (cpha_q) rx_sr = {rx_sr[spims_pkg::RX_W-2:0], c.miso_level};
                     bit_idx = bit_idx + 4'd1;
                     if (bit_idx >= 4'(spims_pkg::WORD_W)) begin
                        xfer_busy = 1'b0;
                        bit_idx   = '0;
                        idle_half = 1'b0;
                        sck_q     = cpol_q;
                        done      = 1'b1;
                        rx        = rx_sr;
                     end else begin
                        tx_sr     = {tx_sr[spims_pkg::TX_W-2:0], 1'b0};
                        mosi_q    = tx_sr[spims_pkg::TX_W-1];
                        sck_q     = ~cpol_q;
                        idle_half = 1'b0;
                     end
                  end
               end
            end
         end
         spims_pkg::CMD_START: begin
            if (!xfer_busy) begin
               xfer_busy = 1'b1;
               bit_idx   = '0;
               idle_half = 1'b0;
               tick_cnt  = '0;
               tx_sr     = c.tx_byte;
               rx_sr     = '0;
               mosi_q    = c.tx_byte[spims_pkg::TX_W-1];
               sck_q     = ~cpol_q;
            end
         end
         spims_pkg::CMD_SELECT: begin
            cs_n_q = ~c.select_level;
         end
         default: begin
         end
      endcase
      r.sck_level  = sck_q;
      r.mosi_level = mosi_q;
      r.cs_n_level = cs_n_q;
      r.busy_res   = xfer_busy;
      r.done_res   = done;
      r.rx_byte    = rx;
      return r;
   endfunction

   // Offer one item, wait for it to be taken, then queue its expected pins.
   task automatic push_item(input spi_cmd_type c, input logic use_fixed,
                            input spims_pkg::result_type fixed);
      spims_pkg::result_type pred;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.mode;
      req_tdata  <= spims_pkg::REQ_DATA_W'({c.miso_level, c.select_level, c.tx_byte});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = next_pins(c);
      pins_due.push_back(use_fixed ? fixed : pred);
   endtask

   // Hold off the sender until every queued result is back and the pipe is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pins_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_clock(input logic [spims_pkg::FREQ_W-1:0] freq,
                                input logic [1:0] spi_mode);
      longint unsigned f;
      longint unsigned h;
      csr_we    <= 1'b1;
      csr_addr  <= spims_pkg::REG_FREQ;
      csr_wdata <= freq;
      @(posedge clock);
      csr_addr  <= spims_pkg::REG_MODE;
      csr_wdata <= spims_pkg::FREQ_W'(spi_mode);
      @(posedge clock);
      csr_we <= 1'b0;
      f = (freq == '0) ? 64'd500000 : 64'(freq);
      h = 64'd1000000 / (64'd2 * f);
      half_ticks = (h == 0) ? 19'd1 : 19'(h);
      cpol_q = spi_mode[1];
      cpha_q = spi_mode[0];
      @(posedge clock);
   endtask

   always @(posedge clock) begin : take_pins
      spims_pkg::result_type got;
      spims_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = spims_pkg::result_type'(rsp_tdata[spims_pkg::RSP_BITS-1:0]);
            if (pins_due.size() == 0) begin
               bad_results++;
               if (bad_results <= MAX_REPORTS)
                  $display("unexpected item: got %h", got);
            end else begin
               want = pins_due.pop_front();
               if (got !== want) begin
                  bad_results++;
                  if (bad_results <= MAX_REPORTS)
                     $display({"pin mismatch (exp/got): sck %b/%b mosi %b/%b",
                               " cs_n %b/%b busy %b/%b done %b/%b rx %h/%h"},
                              want.sck_level, got.sck_level,
                              want.mosi_level, got.mosi_level,
                              want.cs_n_level, got.cs_n_level,
                              want.busy_res, got.busy_res,
                              want.done_res, got.done_res,
                              want.rx_byte, got.rx_byte);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      spi_cmd_type                  c;
      logic [spims_pkg::FREQ_W-1:0] freq;
      logic [1:0]                   spi_mode;
      int                           budget;
      int                           counted;
      int                           pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      half_ticks = 19'd1;
      tick_cnt   = '0;
      bit_idx    = '0;
      idle_half  = 1'b0;
      tx_sr      = '0;
      rx_sr      = '0;
      xfer_busy  = 1'b0;
      sck_q      = 1'b0;
      mosi_q     = 1'b0;
      cs_n_q     = 1'b1;
      cpol_q     = 1'b0;
      cpha_q     = 1'b0;
      send_gap_pct  = 32;
      rsp_stall_pct = 55;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 25; k++)
         push_item(SCRIPT[k].cmd, SCRIPT[k].fixed, SCRIPT[k].pins);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         if (p < FIRST_RANDOM) begin
            freq     = PHASE_FREQ[p];
            spi_mode = PHASE_MODE[p];
         end else begin
            freq     = spims_pkg::FREQ_W'($urandom_range(500000, 31250));
            spi_mode = 2'($urandom_range(3));
         end
         // the 1 Hz setting never finishes a bit, so keep it brief
         budget = (freq == 26'd1) ? 30 : 169;
         if (p < 3) begin
            send_gap_pct  = 32;
            rsp_stall_pct = 55;
         end else if (p < FIRST_RANDOM) begin
            send_gap_pct  = 55;
            rsp_stall_pct = 32;
         end else begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end
         program_clock(freq, spi_mode);

         counted = 0;
         while (counted < budget) begin
            c.tx_byte      = 8'($urandom);
            c.select_level = 1'($urandom);
            c.miso_level   = 1'($urandom);
            pick           = $urandom_range(99);
            if (xfer_busy) begin
               // mostly clock the exchange through, with some noise
               if (pick < 80)      c.mode = spims_pkg::CMD_TICK;
               else if (pick < 86) c.mode = spims_pkg::CMD_START;
               else if (pick < 94) c.mode = spims_pkg::CMD_SELECT;
               else                c.mode = CMD_NOP;
            end else begin
               if (pick < 60)      c.mode = spims_pkg::CMD_START;
               else if (pick < 75) c.mode = spims_pkg::CMD_SELECT;
               else if (pick < 90) c.mode = spims_pkg::CMD_TICK;
               else                c.mode = CMD_NOP;
            end
            push_item(c, 1'b0, '0);
            counted++;
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (bad_results == 0 && pins_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/spims_pkg.sv
hw/rtl/spims_csr.sv
hw/rtl/spims_core.sv
hw/rtl/spi_master_byte_shifter.sv
dv/spi_master_byte_shifter_tb.sv
